// ----- src/obsc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obsc_pkg
// shared types and constants of the box-sphere contact pipeline
// ----------------------------------------------------------------------------
package obsc_pkg;

    localparam int QF         = 30;
    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS  = 31;
    localparam int VAL_W      = 40;
    localparam int IN_DATA_W  = 352;
    localparam int NUM_FIELDS = 9;

    localparam logic signed [31:0] Q_ONE     = 32'sh4000_0000;
    localparam logic signed [31:0] Q_NEG_ONE = -32'sh4000_0000;

    typedef logic signed [31:0]       coord_t;
    typedef logic [30:0]              ext_t;
    typedef logic signed [33:0]       pos_t;
    typedef logic signed [34:0]       diff_t;
    typedef logic signed [63:0]       prod_t;
    typedef logic signed [VAL_W-1:0]  val_t;

    // quat: w, x, y, z from index 0 up
    typedef struct packed {
        logic             mode;
        coord_t [2:0]     p;
        coord_t [3:0]     quat;
        ext_t   [2:0]     half;
        ext_t             rad;
    } pair_t;

    typedef struct packed {
        logic             mode;
        logic             enclosed;
        coord_t [2:0]     p;
        pos_t   [2:0]     q;
        diff_t  [2:0]     r;
        coord_t [2:0]     col;
        ext_t             mn;
        ext_t             rad;
    } geo_t;

    typedef struct packed {
        logic             mode;
        logic             hit;
        logic             enclosed;
        coord_t [2:0]     p;
        pos_t   [2:0]     q;
        ext_t             mn;
        ext_t             rad;
        logic   [2:0][31:0] mag;
        logic   [2:0]     neg;
    } carry_t;

    typedef struct packed {
        carry_t           cx;
        logic   [2:0][30:0] quo;
        logic             len_zero;
    } norm_t;

endpackage

// ----- src/obsc_rotate.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obsc_rotate
// rotation matrix, box-frame offset, clamp, face pick and clamped point
// ----------------------------------------------------------------------------
module obsc_rotate (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            ce,
    input  logic            in_vld,
    input  obsc_pkg::pair_t in_pair,
    output logic            out_vld,
    output obsc_pkg::geo_t  geo
);
    import obsc_pkg::*;

    localparam int STAGES = 7;

    logic [STAGES-1:0] vld_reg;

    pos_t   qp_reg [9];
    pair_t  pair1_reg;
    coord_t rot_next [3][3];
    coord_t rot2_reg [3][3];
    pair_t  pair2_reg;
    prod_t  pt_reg [3][3];
    coord_t rot3_reg [3][3];
    pair_t  pair3_reg;
    pos_t   traw_next [3];
    pos_t   traw4_reg [3];
    coord_t rot4_reg [3][3];
    pair_t  pair4_reg;
    coord_t tc_next [3];
    ext_t   cl_next [3];
    logic   in_next;
    coord_t tc5_reg [3];
    ext_t   cl5_reg [3];
    logic   in5_reg;
    coord_t rot5_reg [3][3];
    pair_t  pair5_reg;
    coord_t col_next [3];
    ext_t   mn_next;
    prod_t  qm6_reg [3][3];
    coord_t col6_reg [3];
    ext_t   mn6_reg;
    logic   in6_reg;
    pair_t  pair6_reg;
    geo_t   geo_next;
    geo_t   geo_reg;

    function automatic pos_t qmul(input coord_t a, input coord_t b);
        prod_t pr;
        pr = a * b;
        return pr[63:30];
    endfunction

    function automatic coord_t clamp_one(input logic signed [36:0] v);
        coord_t res;
        if (v > 37'(Q_ONE))
            res = Q_ONE;
        else if (v < 37'(Q_NEG_ONE))
            res = Q_NEG_ONE;
        else
            res = v[31:0];
        return res;
    endfunction

    function automatic coord_t rot_diag(input pos_t a, input pos_t b);
        logic signed [36:0] s;
        s = 37'(Q_ONE) - ((37'(a) + 37'(b)) <<< 1);
        return clamp_one(s);
    endfunction

    function automatic coord_t rot_off(input pos_t a, input pos_t b, input logic sub);
        logic signed [36:0] s;
        s = sub ? (37'(a) - 37'(b)) : (37'(a) + 37'(b));
        return clamp_one(s <<< 1);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (ce)
            vld_reg <= {vld_reg[STAGES-2:0], in_vld};
    end

    // quaternion products
    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            qp_reg[0] <= qmul(in_pair.quat[2], in_pair.quat[2]); // yy
            qp_reg[1] <= qmul(in_pair.quat[3], in_pair.quat[3]); // zz
            qp_reg[2] <= qmul(in_pair.quat[1], in_pair.quat[2]); // xy
            qp_reg[3] <= qmul(in_pair.quat[0], in_pair.quat[3]); // wz
            qp_reg[4] <= qmul(in_pair.quat[1], in_pair.quat[3]); // xz
            qp_reg[5] <= qmul(in_pair.quat[0], in_pair.quat[2]); // wy
            qp_reg[6] <= qmul(in_pair.quat[1], in_pair.quat[1]); // xx
            qp_reg[7] <= qmul(in_pair.quat[2], in_pair.quat[3]); // yz
            qp_reg[8] <= qmul(in_pair.quat[0], in_pair.quat[1]); // wx
            pair1_reg <= in_pair;
        end
    end

    // rotation matrix entries
    always_comb
    begin
        rot_next[0][0] = rot_diag(qp_reg[0], qp_reg[1]);
        rot_next[0][1] = rot_off(qp_reg[2], qp_reg[3], 1'b1);
        rot_next[0][2] = rot_off(qp_reg[4], qp_reg[5], 1'b0);
        rot_next[1][0] = rot_off(qp_reg[2], qp_reg[3], 1'b0);
        rot_next[1][1] = rot_diag(qp_reg[6], qp_reg[1]);
        rot_next[1][2] = rot_off(qp_reg[7], qp_reg[8], 1'b1);
        rot_next[2][0] = rot_off(qp_reg[4], qp_reg[5], 1'b1);
        rot_next[2][1] = rot_off(qp_reg[7], qp_reg[8], 1'b0);
        rot_next[2][2] = rot_diag(qp_reg[6], qp_reg[0]);
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            rot2_reg  <= rot_next;
            pair2_reg <= pair1_reg;
        end
    end

    // transposed rotation products
    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                    pt_reg[i][j] <= $signed(rot2_reg[j][i]) * $signed(pair2_reg.p[j]);
            rot3_reg  <= rot2_reg;
            pair3_reg <= pair2_reg;
        end
    end

    always_comb
    begin
        prod_t s;
        for (int i = 0; i < 3; i++)
        begin
            s = pt_reg[i][0] + pt_reg[i][1] + pt_reg[i][2];
            traw_next[i] = s[63:30];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            traw4_reg <= traw_next;
            rot4_reg  <= rot3_reg;
            pair4_reg <= pair3_reg;
        end
    end

    // clamp to the extents and clearance per axis
    always_comb
    begin
        pos_t l;
        pos_t tw;
        pos_t at;
        pos_t d;
        in_next = 1'b1;
        for (int i = 0; i < 3; i++)
        begin
            l = $signed({3'b000, pair4_reg.half[i]});
            if (traw4_reg[i] < -l)
            begin
                tw = -l;
                in_next = 1'b0;
            end
            else if (traw4_reg[i] > l)
            begin
                tw = l;
                in_next = 1'b0;
            end
            else
                tw = traw4_reg[i];
            tc_next[i] = tw[31:0];
            at = (tw < 0) ? -tw : tw;
            d = l - at;
            cl_next[i] = d[30:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            tc5_reg   <= tc_next;
            cl5_reg   <= cl_next;
            in5_reg   <= in_next;
            rot5_reg  <= rot4_reg;
            pair5_reg <= pair4_reg;
        end
    end

    // face with least clearance, lowest axis on a tie
    always_comb
    begin
        logic [1:0] best;
        best    = 2'd0;
        mn_next = cl5_reg[0];
        if (cl5_reg[1] < mn_next)
        begin
            mn_next = cl5_reg[1];
            best    = 2'd1;
        end
        if (cl5_reg[2] < mn_next)
        begin
            mn_next = cl5_reg[2];
            best    = 2'd2;
        end
        for (int j = 0; j < 3; j++)
            col_next[j] = ($signed(tc5_reg[best]) > 0) ? rot5_reg[j][best]
                                                        : -rot5_reg[j][best];
    end

    // clamped point back to the world frame
    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                    qm6_reg[i][j] <= $signed(rot5_reg[i][j]) * $signed(tc5_reg[j]);
            col6_reg  <= col_next;
            mn6_reg   <= mn_next;
            in6_reg   <= in5_reg;
            pair6_reg <= pair5_reg;
        end
    end

    always_comb
    begin
        prod_t s;
        pos_t  qv;
        geo_next.mode     = pair6_reg.mode;
        geo_next.enclosed = in6_reg;
        geo_next.p        = pair6_reg.p;
        geo_next.mn       = mn6_reg;
        geo_next.rad      = pair6_reg.rad;
        for (int i = 0; i < 3; i++)
        begin
            s  = qm6_reg[i][0] + qm6_reg[i][1] + qm6_reg[i][2];
            qv = s[63:30];
            geo_next.q[i]   = qv;
            geo_next.r[i]   = 35'($signed(pair6_reg.p[i])) - 35'(qv);
            geo_next.col[i] = col6_reg[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
            geo_reg <= geo_next;
    end

    assign out_vld = vld_reg[STAGES-1];
    assign geo     = geo_reg;

endmodule

// ----- src/obsc_norm.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obsc_norm
// hit test, square root of the length and per-lane normal division
// ----------------------------------------------------------------------------
module obsc_norm (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            ce,
    input  logic            in_vld,
    input  obsc_pkg::geo_t  geo,
    output logic            out_vld,
    output obsc_pkg::norm_t res
);
    import obsc_pkg::*;

    localparam int STAGES = 2 + SQRT_STEPS + DIV_STEPS;

    logic [STAGES-1:0] vld_reg;

    carry_t      cx1_next;
    logic [63:0] sq_next [3];
    logic        over_next;
    logic [63:0] rad2_next;
    carry_t      cx1_reg;
    logic [63:0] sq1_reg [3];
    logic        over1_reg;
    logic [63:0] rad2_reg;
    logic [63:0] d2_next;
    carry_t      cxh_next;

    logic [63:0] rem_reg [SQRT_STEPS];
    logic [63:0] res_reg [SQRT_STEPS+1];
    carry_t      scx_reg [SQRT_STEPS+1];

    logic [63:0] drem_reg [DIV_STEPS-1][3];
    logic [30:0] quo_reg  [DIV_STEPS][3];
    logic [31:0] dlen_reg [DIV_STEPS];
    carry_t      dcx_reg  [DIV_STEPS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (ce)
            vld_reg <= {vld_reg[STAGES-2:0], in_vld};
    end

    // reach check, vector pick and squares
    always_comb
    begin
        logic [34:0] rabs;
        coord_t      v;
        logic [31:0] mag;
        over_next         = 1'b0;
        cx1_next.mode     = geo.mode;
        cx1_next.hit      = 1'b0;
        cx1_next.enclosed = geo.enclosed;
        cx1_next.p        = geo.p;
        cx1_next.q        = geo.q;
        cx1_next.mn       = geo.mn;
        cx1_next.rad      = geo.rad;
        for (int i = 0; i < 3; i++)
        begin
            rabs = geo.r[i][34] ? 35'(-$signed(geo.r[i])) : geo.r[i];
            if (rabs > {4'b0000, geo.rad})
                over_next = 1'b1;
            v   = geo.enclosed ? geo.col[i] : geo.r[i][31:0];
            mag = v[31] ? (~v + 32'd1) : v;
            cx1_next.mag[i] = mag;
            cx1_next.neg[i] = v[31];
            sq_next[i] = 64'(mag) * 64'(mag);
        end
        rad2_next = 64'(geo.rad) * 64'(geo.rad);
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            cx1_reg   <= cx1_next;
            sq1_reg   <= sq_next;
            over1_reg <= over_next;
            rad2_reg  <= rad2_next;
        end
    end

    always_comb
    begin
        d2_next      = sq1_reg[0] + sq1_reg[1] + sq1_reg[2];
        cxh_next     = cx1_reg;
        cxh_next.hit = cx1_reg.enclosed | (!over1_reg && (d2_next <= rad2_reg));
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            rem_reg[0] <= d2_next;
            res_reg[0] <= '0;
            scx_reg[0] <= cxh_next;
        end
    end

    // one root bit per stage
    for (genvar k = 0; k < SQRT_STEPS; k++)
    begin : g_sqrt
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
        logic [63:0] trial;
        logic [63:0] rem_next;
        logic [63:0] res_next;

        always_comb
        begin
            trial = res_reg[k] + BIT;
            if (rem_reg[k] >= trial)
            begin
                rem_next = rem_reg[k] - trial;
                res_next = (res_reg[k] >> 1) + BIT;
            end
            else
            begin
                rem_next = rem_reg[k];
                res_next = res_reg[k] >> 1;
            end
        end

        always_ff @(posedge clk)
        begin
            if (ce)
            begin
                res_reg[k+1] <= res_next;
                scx_reg[k+1] <= scx_reg[k];
            end
        end

        if (k < SQRT_STEPS - 1)
        begin : g_rem
            always_ff @(posedge clk)
            begin
                if (ce)
                    rem_reg[k+1] <= rem_next;
            end
        end
    end

    // one quotient bit per stage in each lane
    for (genvar k = 0; k < DIV_STEPS; k++)
    begin : g_div
        localparam int SH = DIV_STEPS - 1 - k;
        logic [63:0] rem_in [3];
        logic [30:0] quo_in [3];
        logic [31:0] len_in;
        carry_t      cx_in;
        logic [63:0] rem_next [3];
        logic [30:0] quo_next [3];

        if (k == 0)
        begin : g_first
            always_comb
            begin
                len_in = res_reg[SQRT_STEPS][31:0];
                cx_in  = scx_reg[SQRT_STEPS];
                for (int l = 0; l < 3; l++)
                begin
                    rem_in[l] = 64'(scx_reg[SQRT_STEPS].mag[l]) << QF;
                    quo_in[l] = '0;
                end
            end
        end
        else
        begin : g_rest
            always_comb
            begin
                len_in = dlen_reg[k-1];
                cx_in  = dcx_reg[k-1];
                for (int l = 0; l < 3; l++)
                begin
                    rem_in[l] = drem_reg[k-1][l];
                    quo_in[l] = quo_reg[k-1][l];
                end
            end
        end

        always_comb
        begin
            logic [63:0] dv;
            dv = 64'(len_in) << SH;
            for (int l = 0; l < 3; l++)
            begin
                if (rem_in[l] >= dv)
                begin
                    rem_next[l] = rem_in[l] - dv;
                    quo_next[l] = quo_in[l] | (31'd1 << SH);
                end
                else
                begin
                    rem_next[l] = rem_in[l];
                    quo_next[l] = quo_in[l];
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (ce)
            begin
                quo_reg[k]  <= quo_next;
                dlen_reg[k] <= len_in;
                dcx_reg[k]  <= cx_in;
            end
        end

        if (k < DIV_STEPS - 1)
        begin : g_rem
            always_ff @(posedge clk)
            begin
                if (ce)
                    drem_reg[k] <= rem_next;
            end
        end
    end

    always_comb
    begin
        res.cx       = dcx_reg[DIV_STEPS-1];
        res.len_zero = (dlen_reg[DIV_STEPS-1] == '0);
        for (int l = 0; l < 3; l++)
            res.quo[l] = quo_reg[DIV_STEPS-1][l];
    end

    assign out_vld = vld_reg[STAGES-1];

endmodule

// ----- src/obsc_contact.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obsc_contact
// scales the normal, forms contact points and gap, orders and saturates them
// ----------------------------------------------------------------------------
module obsc_contact #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  ce,
    input  logic                                  in_vld,
    input  obsc_pkg::norm_t                       nrm,
    output logic                                  out_vld,
    output logic                                  hit,
    output logic [obsc_pkg::NUM_FIELDS-1:0][COORD_WIDTH-1:0] fields
);
    import obsc_pkg::*;

    localparam int STAGES = 3;

    logic [STAGES-1:0] vld_reg;

    coord_t n_next [3];
    prod_t  m1_reg [3];
    prod_t  m2_reg [3];
    carry_t cx_reg;
    val_t   val_next [NUM_FIELDS];
    val_t   val_reg  [NUM_FIELDS];
    logic   hit2_reg;
    logic   [COORD_WIDTH-1:0] sat_next [NUM_FIELDS];
    logic   [NUM_FIELDS-1:0][COORD_WIDTH-1:0] fld_reg;
    logic   hit3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (ce)
            vld_reg <= {vld_reg[STAGES-2:0], in_vld};
    end

    // signed unit normal
    always_comb
    begin
        coord_t mag;
        for (int i = 0; i < 3; i++)
        begin
            mag = $signed({1'b0, nrm.quo[i]});
            if (nrm.len_zero)
                n_next[i] = '0;
            else
                n_next[i] = nrm.cx.neg[i] ? -mag : mag;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            for (int i = 0; i < 3; i++)
            begin
                m1_reg[i] <= n_next[i] * $signed({1'b0, nrm.cx.mn});
                m2_reg[i] <= n_next[i] * $signed({1'b0, nrm.cx.rad});
            end
            cx_reg <= nrm.cx;
        end
    end

    // points and gap, swapped when the sphere is first
    always_comb
    begin
        pos_t s1;
        pos_t s2;
        val_t pv;
        val_t p1;
        val_t p2;
        val_t a;
        val_t b;
        val_t g;
        for (int i = 0; i < 3; i++)
        begin
            s1 = m1_reg[i][63:30];
            s2 = m2_reg[i][63:30];
            pv = val_t'($signed(cx_reg.p[i]));
            p1 = cx_reg.enclosed ? (pv + val_t'(s1)) : val_t'($signed(cx_reg.q[i]));
            p2 = pv - val_t'(s2);
            a  = p1;
            b  = -val_t'(s2);
            g  = p1 - p2;
            if (cx_reg.mode)
            begin
                a = -val_t'(s2);
                b = p1;
                g = p2 - p1;
            end
            if (!cx_reg.hit)
            begin
                a = '0;
                b = '0;
                g = '0;
            end
            val_next[i]     = a;
            val_next[3 + i] = b;
            val_next[6 + i] = g;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            val_reg  <= val_next;
            hit2_reg <= cx_reg.hit;
        end
    end

    if (COORD_WIDTH >= VAL_W)
    begin : g_wide
        always_comb
        begin
            for (int f = 0; f < NUM_FIELDS; f++)
                sat_next[f] = COORD_WIDTH'(val_reg[f]);
        end
    end
    else
    begin : g_sat
        localparam val_t SAT_MAX = val_t'((64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1);
        localparam val_t SAT_MIN = -SAT_MAX - val_t'(1);
        always_comb
        begin
            for (int f = 0; f < NUM_FIELDS; f++)
            begin
                if (val_reg[f] > SAT_MAX)
                    sat_next[f] = SAT_MAX[COORD_WIDTH-1:0];
                else if (val_reg[f] < SAT_MIN)
                    sat_next[f] = SAT_MIN[COORD_WIDTH-1:0];
                else
                    sat_next[f] = val_reg[f][COORD_WIDTH-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            for (int f = 0; f < NUM_FIELDS; f++)
                fld_reg[f] <= sat_next[f];
            hit3_reg <= hit2_reg;
        end
    end

    assign out_vld = vld_reg[STAGES-1];
    assign hit     = hit3_reg;
    assign fields  = fld_reg;

endmodule

// ----- src/oriented_box_sphere_contact_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oriented_box_sphere_contact_unit
// contact between an oriented box and a sphere, one pair per beat
// ----------------------------------------------------------------------------
//  channel   | direction | carries
//  s_axis    | in        | box-sphere pair: offset, quaternion, extents, radius
//  m_axis    | out       | hit flag, both contact points and their gap
//
// one pair is accepted every cycle unless m_axis is stalled; each result goes
// through 7 rotation stages, 2 hit stages, 32 square root and 31 division stages
// and 3 output stages. the square root and divider set the depth, one bit per
// stage. reset clears only the valid bits. a stall on m_axis freezes the whole
// pipeline in place, so nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module oriented_box_sphere_contact_unit #(
    parameter  int COORD_WIDTH = 32,
    localparam int OUT_DATA_W  = ((9 * COORD_WIDTH + 7) / 8) * 8
) (
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // rel_x, rel_y, rel_z, quat_w, quat_x, quat_y, quat_z,
    // half_x, half_y, half_z, sphere_radius, zero pad
    input  logic [obsc_pkg::IN_DATA_W-1:0] s_axis_tdata,
    // mode
    input  logic                  s_axis_tuser,

    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // first_point_x/y/z, second_point_x/y/z, gap_x/y/z, zero pad
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // hit
    output logic                  m_axis_tuser
);
    import obsc_pkg::*;

    logic   ce;
    pair_t  pair;
    logic   rot_vld;
    geo_t   geo;
    logic   nrm_vld;
    norm_t  nrm;
    logic   [NUM_FIELDS-1:0][COORD_WIDTH-1:0] fields;

    // whole pipeline moves unless the output beat is held
    assign ce            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = ce;

    // unpack the input beat
    always_comb
    begin
        pair.mode    = s_axis_tuser;
        pair.p[0]    = s_axis_tdata[31:0];
        pair.p[1]    = s_axis_tdata[63:32];
        pair.p[2]    = s_axis_tdata[95:64];
        pair.quat[0] = s_axis_tdata[127:96];
        pair.quat[1] = s_axis_tdata[159:128];
        pair.quat[2] = s_axis_tdata[191:160];
        pair.quat[3] = s_axis_tdata[223:192];
        pair.half[0] = s_axis_tdata[254:224];
        pair.half[1] = s_axis_tdata[285:255];
        pair.half[2] = s_axis_tdata[316:286];
        pair.rad     = s_axis_tdata[347:317];
    end

    // box frame, clamp and face pick
    obsc_rotate u_rotate (
        .clk     (clk),
        .rst_n   (rst_n),
        .ce      (ce),
        .in_vld  (s_axis_tvalid),
        .in_pair (pair),
        .out_vld (rot_vld),
        .geo     (geo)
    );

    // hit test and unit normal
    obsc_norm u_norm (
        .clk     (clk),
        .rst_n   (rst_n),
        .ce      (ce),
        .in_vld  (rot_vld),
        .geo     (geo),
        .out_vld (nrm_vld),
        .res     (nrm)
    );

    // contact points, ordering and saturation; holds the output beat
    obsc_contact #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_contact (
        .clk     (clk),
        .rst_n   (rst_n),
        .ce      (ce),
        .in_vld  (nrm_vld),
        .nrm     (nrm),
        .out_vld (m_axis_tvalid),
        .hit     (m_axis_tuser),
        .fields  (fields)
    );

    // pack the output beat
    for (genvar f = 0; f < NUM_FIELDS; f++)
    begin : g_pack
        assign m_axis_tdata[f*COORD_WIDTH +: COORD_WIDTH] = fields[f];
    end

    if (OUT_DATA_W > NUM_FIELDS * COORD_WIDTH)
    begin : g_pad
        assign m_axis_tdata[OUT_DATA_W-1:NUM_FIELDS*COORD_WIDTH] = '0;
    end

endmodule

// ----- sim/tb_oriented_box_sphere_contact_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_oriented_box_sphere_contact_unit
// self-checking bench for the box-sphere contact pipeline
// ----------------------------------------------------------------------------
// pairs go in on s_axis, a contact model in the bench predicts hit flag,
// both contact points and their gap, and every m_axis beat is checked
// field by field against the oldest prediction. directed corner pairs come
// first, then random pairs under several idling and stall patterns.
// ----------------------------------------------------------------------------
module tb_oriented_box_sphere_contact_unit;

    import obsc_pkg::*;

    localparam longint ONE_Q  = 64'sd1 << 30;
    localparam longint CMAX   = 64'sd2147483647;
    localparam longint CMIN   = -64'sd2147483648;
    localparam int     LIMIT  = 600000;
    localparam int     DRAIN  = 200;

    // one box-sphere pair as it travels on s_axis
    typedef struct {
        bit                 mode;
        logic signed [31:0] rel [3];
        logic signed [31:0] quat [4];   // w, x, y, z
        logic [30:0]        half [3];
        logic [30:0]        rad;
    } pair_item_t;

    // one contact: first point, second point, gap, each x/y/z
    typedef struct {
        bit                 hit;
        logic signed [31:0] v [9];
    } contact_t;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [IN_DATA_W-1:0] s_axis_tdata;
    logic         s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [287:0] m_axis_tdata;
    logic         m_axis_tuser;

    contact_t     expected_contacts [$];
    int           errors;
    int           cycles;
    int           send_idle_pct;
    int           stall_pct;

    oriented_box_sphere_contact_unit uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // ------------------------------------------------------------------
    // contact model
    // ------------------------------------------------------------------
    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint mag(longint v);
        return v < 0 ? -v : v;
    endfunction

    // quaternion product, floored back to q2.30
    function automatic longint qprod(longint a, longint b);
        return (a * b) >>> 30;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= root + bitv)
            begin
                v    = v - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
                root = root >> 1;
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    // unit direction in q2.30, truncated toward zero; zero vector stays zero
    function automatic void unit_dir(input longint v [3], output longint n [3]);
        longint unsigned d2;
        longint          len;
        d2 = 0;
        for (int i = 0; i < 3; i++)
            d2 += longint'(mag(v[i])) * longint'(mag(v[i]));
        len = longint'(int_sqrt(d2));
        for (int i = 0; i < 3; i++)
            n[i] = (len == 0) ? 0 : clip((v[i] * ONE_Q) / len, -ONE_Q, ONE_Q);
    endfunction

    function automatic contact_t predict_contact(pair_item_t it);
        longint p [3], lim [3], t [3], q [3], r [3], n [3], col [3];
        longint p1 [3], p2 [3];
        longint rot [3][3];
        longint w, x, y, z, rad, mn, s, a, b, g;
        longint unsigned d2;
        bit enclosed, hit;
        int best;
        contact_t res;
        for (int i = 0; i < 3; i++)
        begin
            p[i]   = longint'(it.rel[i]);
            lim[i] = longint'(it.half[i]);
        end
        rad = longint'(it.rad);
        w = longint'(it.quat[0]);
        x = longint'(it.quat[1]);
        y = longint'(it.quat[2]);
        z = longint'(it.quat[3]);
        rot[0][0] = ONE_Q - 2 * (qprod(y, y) + qprod(z, z));
        rot[0][1] = 2 * (qprod(x, y) - qprod(w, z));
        rot[0][2] = 2 * (qprod(x, z) + qprod(w, y));
        rot[1][0] = 2 * (qprod(x, y) + qprod(w, z));
        rot[1][1] = ONE_Q - 2 * (qprod(x, x) + qprod(z, z));
        rot[1][2] = 2 * (qprod(y, z) - qprod(w, x));
        rot[2][0] = 2 * (qprod(x, z) - qprod(w, y));
        rot[2][1] = 2 * (qprod(y, z) + qprod(w, x));
        rot[2][2] = ONE_Q - 2 * (qprod(x, x) + qprod(y, y));
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                rot[i][j] = clip(rot[i][j], -ONE_Q, ONE_Q);

        // offset into box axes, clamped to the extents
        enclosed = 1;
        hit      = 1;
        for (int i = 0; i < 3; i++)
        begin
            s = 0;
            for (int j = 0; j < 3; j++)
                s += rot[j][i] * p[j];
            t[i] = s >>> 30;
            if (t[i] < -lim[i])
            begin
                t[i] = -lim[i];
                enclosed = 0;
            end
            if (t[i] > lim[i])
            begin
                t[i] = lim[i];
                enclosed = 0;
            end
        end

        if (enclosed)
        begin
            // face with least clearance, lowest axis on a tie
            best = 0;
            mn   = lim[0] - mag(t[0]);
            for (int i = 1; i < 3; i++)
                if (lim[i] - mag(t[i]) < mn)
                begin
                    mn   = lim[i] - mag(t[i]);
                    best = i;
                end
            for (int j = 0; j < 3; j++)
                col[j] = (t[best] > 0) ? rot[j][best] : -rot[j][best];
            unit_dir(col, n);
            for (int i = 0; i < 3; i++)
            begin
                p1[i] = p[i] + ((n[i] * mn) >>> 30);
                p2[i] = p[i] - ((n[i] * rad) >>> 30);
            end
        end
        else
        begin
            for (int i = 0; i < 3; i++)
            begin
                s = 0;
                for (int j = 0; j < 3; j++)
                    s += rot[i][j] * t[j];
                q[i] = s >>> 30;
                r[i] = p[i] - q[i];
                if (mag(r[i]) > rad)
                    hit = 0;
            end
            if (hit)
            begin
                d2 = 0;
                for (int i = 0; i < 3; i++)
                    d2 += longint'(mag(r[i])) * longint'(mag(r[i]));
                if (d2 > longint'(rad) * longint'(rad))
                    hit = 0;
            end
            if (hit)
            begin
                unit_dir(r, n);
                for (int i = 0; i < 3; i++)
                begin
                    p1[i] = q[i];
                    p2[i] = p[i] - ((n[i] * rad) >>> 30);
                end
            end
        end

        res.hit = hit;
        for (int i = 0; i < 3; i++)
        begin
            a = 0;
            b = 0;
            g = 0;
            if (hit)
            begin
                a = p1[i];
                b = p2[i] - p[i];
                g = p1[i] - p2[i];
                if (it.mode)
                begin
                    s = a;
                    a = b;
                    b = s;
                    g = -g;
                end
            end
            res.v[i]     = 32'(clip(a, CMIN, CMAX));
            res.v[3 + i] = 32'(clip(b, CMIN, CMAX));
            res.v[6 + i] = 32'(clip(g, CMIN, CMAX));
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // pair sender: valid stays high across back-to-back beats
    // ------------------------------------------------------------------
    task automatic send_pair(pair_item_t it);
        if ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= it.mode;
        s_axis_tdata  <= {4'b0, it.rad, it.half[2], it.half[1], it.half[0],
                          it.quat[3], it.quat[2], it.quat[1], it.quat[0],
                          it.rel[2], it.rel[1], it.rel[0]};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        expected_contacts = {expected_contacts, predict_contact(it)};
    endtask

    // receiver stall pattern
    always @(posedge clk)
        m_axis_tready <= ($urandom_range(99) >= stall_pct);

    // result checker
    always @(posedge clk)
    begin
        contact_t exp_c;
        logic signed [31:0] got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_contacts.size() == 0)
            begin
                $display("%0t: unexpected result beat, expected none, actual hit %0b",
                         $time, m_axis_tuser);
                errors++;
            end
            else
            begin
                exp_c = expected_contacts.pop_front();
                if (m_axis_tuser !== exp_c.hit)
                begin
                    $display("%0t: hit mismatch, expected %0b actual %0b",
                             $time, exp_c.hit, m_axis_tuser);
                    errors++;
                end
                for (int k = 0; k < 9; k++)
                begin
                    got = m_axis_tdata[32*k +: 32];
                    if (got !== exp_c.v[k])
                    begin
                        $display("%0t: field %0d mismatch, expected %0d actual %0d",
                                 $time, k, exp_c.v[k], got);
                        errors++;
                    end
                end
            end
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // pair builders
    // ------------------------------------------------------------------
    function automatic pair_item_t make_pair(bit mode, int rx, int ry, int rz,
                                             int qw, int qx, int qy, int qz,
                                             int hx, int hy, int hz, int rad);
        pair_item_t it;
        it.mode    = mode;
        it.rel[0]  = rx;
        it.rel[1]  = ry;
        it.rel[2]  = rz;
        it.quat[0] = qw;
        it.quat[1] = qx;
        it.quat[2] = qy;
        it.quat[3] = qz;
        it.half[0] = 31'(hx);
        it.half[1] = 31'(hy);
        it.half[2] = 31'(hz);
        it.rad     = 31'(rad);
        return it;
    endfunction

    // unit quaternion from random components, or a raw one now and then
    function automatic void random_quat(ref pair_item_t it);
        real c [4];
        real nrm;
        int  pick;
        pick = $urandom_range(9);
        if (pick == 0)
        begin
            for (int i = 0; i < 4; i++)
                it.quat[i] = $urandom;
            return;
        end
        if (pick == 1)
        begin
            for (int i = 0; i < 4; i++)
                it.quat[i] = 0;
            it.quat[$urandom_range(3)] = $urandom_range(1) ? Q_ONE : Q_NEG_ONE;
            return;
        end
        nrm = 0.0;
        for (int i = 0; i < 4; i++)
        begin
            c[i] = real'($signed($urandom_range(2000000))) - 1000000.0;
            nrm += c[i] * c[i];
        end
        nrm = $sqrt(nrm);
        if (nrm < 1.0)
        begin
            c[0] = 1.0;
            nrm  = 1.0;
        end
        for (int i = 0; i < 4; i++)
            it.quat[i] = $rtoi(c[i] / nrm * 1073741823.0);
    endfunction

    function automatic pair_item_t random_pair();
        pair_item_t it;
        int span;
        it.mode = $urandom_range(1);
        random_quat(it);
        if ($urandom_range(9) == 0)
        begin
            // raw noise across every bit
            for (int i = 0; i < 3; i++)
            begin
                it.rel[i]  = $urandom;
                it.half[i] = 31'($urandom);
            end
            it.rad = 31'($urandom);
            return it;
        end
        span = 1 << $urandom_range(8, 22);
        for (int i = 0; i < 3; i++)
            it.half[i] = 31'($urandom_range(span));
        it.rad = 31'($urandom_range(span));
        // offsets near the box so inside, touching and missing all occur
        for (int i = 0; i < 3; i++)
            it.rel[i] = $signed($urandom_range(4 * span)) - 2 * span;
        return it;
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_directed();
        int h;
        h = 32'h0001_0000;
        send_idle_pct = 0;
        stall_pct     = 0;
        // all zero: degenerate box, center inside, zero clearance
        send_pair(make_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        // center at box center, equal extents: tie goes to x, normal along -x
        send_pair(make_pair(0, 0, 0, 0, Q_ONE, 0, 0, 0, h, h, h, h / 2));
        send_pair(make_pair(1, 0, 0, 0, Q_ONE, 0, 0, 0, h, h, h, h / 2));
        // inside, nearest face y, then z
        send_pair(make_pair(0, 100, h - 10, 0, Q_ONE, 0, 0, 0, h, h, h, h));
        send_pair(make_pair(1, 100, 5, -(h - 3), Q_ONE, 0, 0, 0, h, h, h, h));
        // outside touching, outside just missing
        send_pair(make_pair(0, 2 * h, 0, 0, Q_ONE, 0, 0, 0, h, h, h, h));
        send_pair(make_pair(0, 2 * h + 1, 0, 0, Q_ONE, 0, 0, 0, h, h, h, h));
        // corner region
        send_pair(make_pair(1, 3 * h / 2, 3 * h / 2, 3 * h / 2, Q_ONE, 0, 0, 0,
                            h, h, h, h));
        // rotated 90 degrees about z, then a negative scalar part
        send_pair(make_pair(0, 0, 3 * h / 2, 0, 32'sh2D41_3CCD, 0, 0, 32'sh2D41_3CCD,
                            2 * h, h / 2, h, h));
        send_pair(make_pair(1, h, 0, 0, Q_NEG_ONE, 0, 0, 0, h, 2 * h, h, h));
        // offset extremes with huge radius, huge box and then empty box
        send_pair(make_pair(0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, Q_ONE,
                            0, 0, 0, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
                            31'h7FFF_FFFF));
        send_pair(make_pair(1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, Q_ONE,
                            0, 0, 0, 0, 0, 0, 31'h7FFF_FFFF));
        // zero quaternion, mirrored axes
        send_pair(make_pair(0, h, -h, h / 3, 0, 0, 0, 0, h, h, h, 4 * h));
        send_pair(make_pair(1, -h, h / 4, 0, 0, Q_ONE, 0, 0, h, h, h, 2 * h));
        send_pair(make_pair(0, 7, 3 * h, -9, 0, 0, Q_NEG_ONE, 0, h, h, h, 3 * h));
        send_pair(make_pair(1, -3 * h, 1, 1, 0, 0, 0, Q_ONE, h, 2 * h, h, 3 * h));
        // non-unit quaternion with full-scale parts
        send_pair(make_pair(0, h, h, h, Q_ONE, Q_ONE, Q_NEG_ONE, Q_ONE, h, h, h, 2 * h));
        send_pair(make_pair(1, 32'h7FFF_FFFF, 0, 0, Q_ONE, 0, 0, 0, 31'h7FFF_FFFF,
                            0, 0, 0));
        send_pair(make_pair(0, 0, 0, 0, Q_ONE, 0, 0, 0, 0, 0, 0, 31'h7FFF_FFFF));
    endtask

    task automatic test_random(int count, int idle_pct, int stall);
        send_idle_pct = idle_pct;
        stall_pct     = stall;
        repeat (count)
            send_pair(random_pair());
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        m_axis_tready = 1'b1;
        errors        = 0;
        cycles        = 0;
        send_idle_pct = 0;
        stall_pct     = 0;
        repeat (12)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random(450, 0, 0);
        test_random(450, 83, 0);
        test_random(450, 0, 83);
        test_random(400, 25, 25);
        s_axis_tvalid <= 1'b0;

        // drain the pipeline
        while (expected_contacts.size() != 0)
            @(posedge clk);
        repeat (DRAIN)
            @(posedge clk);

        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ----- oriented_box_sphere_contact_unit.f -----
src/obsc_pkg.sv
src/obsc_rotate.sv
src/obsc_norm.sv
src/obsc_contact.sv
src/oriented_box_sphere_contact_unit.sv
sim/tb_oriented_box_sphere_contact_unit.sv
